// ===== design/bdac_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the word width, the digit count and the character codes.
// No dependencies.
package bdac_pkg;

  localparam int WIDTH = 32;
  // Decimal digits that a WIDTH-bit magnitude can need (log10(2) ~ 0.30103).
  localparam int NDIG = (WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [3:0] BCD_FIVE   = 4'd5;
  localparam logic [3:0] BCD_THREE  = 4'd3;

endpackage

// ===== design/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII converter.
// Bit-serial double-dabble conversion followed by a character sequencer.
// Depends on bdac_pkg.
//
//   channel   signals                          beat taken when
//   input     start, busy, value               start high and busy low
//   result    strobe, ascii_char, last_char    strobe high (one cycle, no stall)
//
// An item is shifted WIDTH times (32) through the one add-3/shift unit,
// then the characters follow: sign if negative, then each digit from the
// most significant nonzero one down. busy is high while the block converts
// or sends characters, and falls as the last character reaches the outputs.
// Reset is synchronous and returns the sequencer to idle.
// The receiver cannot stall; characters leave one per cycle.
module binary_to_decimal_ascii_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bdac_pkg::WIDTH-1:0] value,
  output logic                      strobe,
  output logic [7:0]                ascii_char,
  output logic                      last_char
);
  import bdac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state;
  logic [WIDTH-1:0]   mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_next;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   lead;
  logic               neg;
  logic [3:0]         digit;

  // Add 3 to every digit of 5 or more, then shift one magnitude bit in.
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= BCD_FIVE) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + BCD_THREE;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
    bcd_next = {bcd_adj[BCD_W-2:0], mag[WIDTH-1]};
  end

  // Position of the most significant nonzero digit of the finished result.
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_next[d*4 +: 4] != 4'd0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign digit = bcd[idx*4 +: 4];
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= value[WIDTH-1];
            mag   <= value[WIDTH-1] ? (~value + 1'b1) : value;
            bcd   <= '0;
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          bcd <= bcd_next;
          mag <= {mag[WIDTH-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(WIDTH - 1)) begin
            idx   <= lead;
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          strobe     <= 1'b1;
          ascii_char <= CHAR_MINUS;
          last_char  <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          ascii_char <= CHAR_ZERO + {4'd0, digit};
          last_char  <= (idx == '0);
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
